[rtl/khwe_pkg.sv]
// Package for the key history word extractor: widths, command and key codes,
// and the front-to-back command record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package khwe_pkg;
  localparam int DEPTH_DEF = 64;
  localparam int KEY_BITS  = 16;
  localparam int CNT_W     = 7;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_DROP    = 2'd2;
  localparam logic [1:0] CMD_EXTRACT = 2'd3;

  localparam logic [1:0] KT_SPACE   = 2'd1;
  localparam logic [1:0] KT_COMMAND = 2'd3;

  // Command record handed from the front to the back
  typedef struct packed {
    logic [1:0]          command;
    logic [1:0]          key_type;
    logic [KEY_BITS-1:0] key_data;
    logic [CNT_W-1:0]    count;
  } cmd_t;
endpackage
`default_nettype wire

[rtl/key_history_word_extractor_unit.sv]
// Top level of the key history word extractor: APB register, front queue
// and back end. Depends on khwe_pkg, khwe_front, khwe_back.
`timescale 1ns / 1ps
`default_nettype none
// Push, clear and drop each give one result, registered in the back end
// after the command queue. An extract reads the history ring through a
// single registered RAM port: one read of the newest entry, then a read
// and a classify step per entry walked backward, then a read per collected
// key when replaying oldest first. A two-entry command queue accepts items
// while the back end works; a new command starts only once the previous
// result has been taken.
module key_history_word_extractor_unit #(
  parameter int DEPTH = khwe_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: command[1:0], key_type[3:2], key_data[19:4], count[26:20]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: valid_res[0], out_type[2:1], out_data[18:3], backspaces[25:19], fill[32:26]
  output logic [39:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [khwe_pkg::CNT_W-1:0] max_size_r;
  logic           cfg_we, q_valid, q_pop;
  khwe_pkg::cmd_t in_cmd, q_cmd;
  logic [33:0]    res;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {25'd0, max_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) max_size_r <= 7'd64;
    else if (cfg_we) max_size_r <= cfg_pwdata[6:0];
  end

  assign in_cmd = '{command: in_tdata[1:0], key_type: in_tdata[3:2],
                    key_data: in_tdata[19:4], count: in_tdata[26:20]};

  khwe_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  khwe_back #(.DEPTH(DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .max_size(max_size_r), .cfg_we(cfg_we), .cfg_size(cfg_pwdata[6:0]),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res)
  );

  // res: last, fill, backspaces, data, type, valid
  assign out_tlast = res[33];
  assign out_tdata = {7'd0, res[32:0]};
endmodule
`default_nettype wire

[rtl/khwe_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module khwe_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/khwe_front.sv]
// Front end: accepts input transactions into a two-entry command queue.
// Depends on khwe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module khwe_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire khwe_pkg::cmd_t  in_cmd,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output khwe_pkg::cmd_t       q_cmd
);
  khwe_pkg::cmd_t slot_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= in_cmd;
  end
endmodule
`default_nettype wire

[rtl/khwe_back.sv]
// Back end: history ring, push/clear/drop updates and the backward word walk
// with forward replay of collected keys. Depends on khwe_pkg and khwe_ram.
`timescale 1ns / 1ps
`default_nettype none
module khwe_back #(
  parameter int DEPTH = khwe_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  input  wire khwe_pkg::cmd_t              q_cmd,
  input  wire logic [khwe_pkg::CNT_W-1:0]  max_size,
  input  wire logic                        cfg_we,
  input  wire logic [khwe_pkg::CNT_W-1:0]  cfg_size,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [33:0]                      res_data
);
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = khwe_pkg::CNT_W;
  localparam int KB  = khwe_pkg::KEY_BITS;
  localparam int EW  = KB + 2;
  localparam int CAP = (DEPTH < 64) ? DEPTH : 64;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_ERD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] np_r, np_nxt;
  logic [CW-1:0] ec_r, ec_nxt;
  logic [CW-1:0] age_r, age_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] words_r, words_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          trail_r, trail_nxt;
  logic          ov_r, ov_nxt;
  logic [33:0]   od_r, od_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [CW-1:0] emax, cfg_emax, cfg_clip;
  logic [1:0]    rtype;

  // Effective size clamp 1..CAP
  function automatic logic [CW-1:0] size_clamp(input logic [CW-1:0] sz);
    logic [CW-1:0] m;
    m = sz;
    if (m == '0) m = CW'(1);
    if (m > CW'(CAP)) m = CW'(CAP);
    return m;
  endfunction

  // Ring spans the full address range so pointer wrap stays in bounds
  khwe_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign emax     = size_clamp(max_size);
  // A register write trims the fill to the newly written size
  assign cfg_emax = size_clamp(cfg_size);
  assign cfg_clip = (ec_r > cfg_emax) ? cfg_emax : ec_r;

  assign rtype     = rdata[EW-1 -: 2];
  assign res_valid = ov_r;
  assign res_data  = od_r;

  always_comb begin
    st_nxt = st_r; np_nxt = np_r; ec_nxt = ec_r; age_nxt = age_r; n_nxt = n_r;
    words_nxt = words_r; i_nxt = i_r; cnt_nxt = cnt_r; trail_nxt = trail_r;
    ov_nxt = ov_r && !res_ready; od_nxt = od_r;
    q_pop = 1'b0; we = 1'b0;
    waddr = np_r + AW'(1);
    wdata = {q_cmd.key_type, q_cmd.key_data};
    raddr = np_r - AW'(age_r);
    if (cfg_we) ec_nxt = cfg_clip;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          q_pop = 1'b1;
          case (q_cmd.command)
            khwe_pkg::CMD_PUSH: begin
              if (q_cmd.key_type == khwe_pkg::KT_COMMAND) ec_nxt = '0;
              else begin
                we = 1'b1;
                np_nxt = np_r + AW'(1);
                ec_nxt = (ec_r >= emax) ? emax : ec_r + CW'(1);
              end
            end
            khwe_pkg::CMD_CLEAR: ec_nxt = '0;
            khwe_pkg::CMD_DROP:
              ec_nxt = (q_cmd.count >= ec_r) ? '0 : ec_r - q_cmd.count;
            default: ;
          endcase
          if (q_cmd.command == khwe_pkg::CMD_EXTRACT && ec_r != '0 &&
              q_cmd.count != '0) begin
            cnt_nxt = q_cmd.count; age_nxt = '0; n_nxt = '0; words_nxt = '0;
            trail_nxt = 1'b1; st_nxt = ST_RD;
          end else begin
            ov_nxt = 1'b1;
            od_nxt = {1'b1, ec_nxt, 7'd0, 16'd0, 2'd0, 1'b0};
          end
        end
      end
      ST_RD: st_nxt = ST_WALK;
      // Each entry walked: read issue in ST_RD, then classify in ST_WALK
      ST_WALK: begin
        if (age_r >= ec_r || n_r >= CW'(64) || (!trail_r && words_r >= cnt_r))
          st_nxt = ST_EMIT;
        else begin
          st_nxt = ST_RD;
          age_nxt = age_r + CW'(1);
          if (trail_r && rtype == khwe_pkg::KT_SPACE) n_nxt = n_r + CW'(1);
          else begin
            trail_nxt = 1'b0;
            if (rtype == khwe_pkg::KT_SPACE) begin
              words_nxt = words_r + CW'(1);
              if (words_r + CW'(1) < cnt_r) n_nxt = n_r + CW'(1);
            end else n_nxt = n_r + CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (n_r == '0) begin
          ov_nxt = 1'b1;
          od_nxt = {1'b1, ec_r, 7'd0, 16'd0, 2'd0, 1'b0};
          st_nxt = ST_IDLE;
        end else begin
          i_nxt = '0; age_nxt = n_r - CW'(1); st_nxt = ST_ERD;
        end
      end
      ST_ERD: st_nxt = ST_OUT;
      // Collected keys are the n newest minus skipped boundary; replay oldest first
      ST_OUT: begin
        if (!ov_r || res_ready) begin
          ov_nxt = 1'b1;
          od_nxt = {(i_r + CW'(1) == n_r), ec_r, n_r,
                    rdata[KB-1:0], rtype, 1'b1};
          i_nxt = i_r + CW'(1);
          if (i_r + CW'(1) == n_r) st_nxt = ST_IDLE;
          else begin
            age_nxt = age_r - CW'(1); st_nxt = ST_ERD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; np_r <= '0; ec_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; np_r <= np_nxt; ec_r <= ec_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    age_r <= age_nxt; n_r <= n_nxt; words_r <= words_nxt; i_r <= i_nxt;
    cnt_r <= cnt_nxt; trail_r <= trail_nxt; od_r <= od_nxt;
  end
endmodule
`default_nettype wire
